@@ rtl/pidz_pkg.sv @@
package pidz_pkg;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DRV_W   = 24;
  localparam int LIM_W   = 23;
  localparam int ACC_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int FRAC_W  = 8;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_ZONE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_EXIT_THRESHOLD = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_DRIVE      = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_DRIVE      = 3'd6;
  localparam logic [IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [15:0]       integral_zone;
    logic [15:0]       exit_threshold;
    logic [LIM_W-1:0]  min_drive;
    logic [LIM_W-1:0]  max_drive;
    logic [TIME_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] prev_err;
    logic signed [ERR_W-1:0] last_err;
    logic signed [ACC_W-1:0] integ_acc;
    logic                    first_sample;
    logic [TIME_W-1:0]       elapsed;
    logic signed [DRV_W-1:0] last_drive;
  } state_t;

endpackage

@@ rtl/pidz_calc.sv @@
module pidz_calc (
  input  pidz_pkg::cfg_t                       cfg,
  input  pidz_pkg::state_t                     st,
  input  logic [1:0]                           op,
  input  logic signed [pidz_pkg::ERR_W-1:0]    err,
  output pidz_pkg::state_t                     st_next,
  output logic                                 fin_next
);

  localparam int P_W   = pidz_pkg::GAIN_W + 1 + pidz_pkg::ERR_W;
  localparam int D_W   = pidz_pkg::GAIN_W + 1 + pidz_pkg::ERR_W + 1;
  localparam int I_W   = pidz_pkg::GAIN_W + 1 + pidz_pkg::ACC_W;
  localparam int TOT_W = I_W - pidz_pkg::FRAC_W + 2;
  localparam int F     = pidz_pkg::FRAC_W;

  logic signed [pidz_pkg::ERR_W-1:0]   prev_use;
  logic signed [pidz_pkg::ERR_W:0]     err_x;
  logic [pidz_pkg::ERR_W:0]            abs_e;
  logic [pidz_pkg::ERR_W:0]            abs_last;
  logic signed [pidz_pkg::ERR_W:0]     diff;
  logic signed [pidz_pkg::ACC_W:0]     acc_sum;
  logic signed [pidz_pkg::ACC_W-1:0]   acc_sat;
  logic signed [pidz_pkg::ACC_W-1:0]   acc_new;
  logic signed [P_W-1:0]               prod_p;
  logic signed [D_W-1:0]               prod_d;
  logic signed [I_W-1:0]               prod_i;
  logic signed [P_W-1:0]               adj_p;
  logic signed [D_W-1:0]               adj_d;
  logic signed [I_W-1:0]               adj_i;
  logic signed [P_W-F-1:0]             p_q;
  logic signed [D_W-F-1:0]             d_q;
  logic signed [I_W-F-1:0]             i_q;
  logic signed [TOT_W-1:0]             total;
  logic signed [TOT_W-1:0]             t1;
  logic signed [TOT_W-1:0]             t2;
  logic [TOT_W-1:0]                    mag0;
  logic [TOT_W-1:0]                    mag1;
  logic signed [TOT_W-1:0]             lim_max;
  logic signed [TOT_W-1:0]             lim_min;
  logic signed [TOT_W-1:0]             max_x;
  logic signed [TOT_W-1:0]             min_x;

  always_comb begin
    err_x    = {err[pidz_pkg::ERR_W-1], err};
    abs_e    = err_x[pidz_pkg::ERR_W] ? $unsigned(-err_x) : $unsigned(err_x);
    prev_use = st.first_sample ? err : st.prev_err;
    diff     = err_x - {prev_use[pidz_pkg::ERR_W-1], prev_use};

    // saturating integral, cleared outside the zone
    acc_sum = {st.integ_acc[pidz_pkg::ACC_W-1], st.integ_acc}
              + {{(pidz_pkg::ACC_W-pidz_pkg::ERR_W){err_x[pidz_pkg::ERR_W]}}, err_x};
    if (acc_sum[pidz_pkg::ACC_W] != acc_sum[pidz_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[pidz_pkg::ACC_W] ? {1'b1, {(pidz_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(pidz_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[pidz_pkg::ACC_W-1:0];
    end
    acc_new = (abs_e < {1'b0, cfg.integral_zone}) ? acc_sat : '0;

    prod_p = $signed({1'b0, cfg.prop_gain}) * err;
    prod_d = $signed({1'b0, cfg.deriv_gain}) * diff;
    prod_i = $signed({1'b0, cfg.integ_gain}) * acc_new;

    // q8.8 truncation toward zero
    adj_p = prod_p + (prod_p[P_W-1] ? P_W'(255) : P_W'(0));
    adj_d = prod_d + (prod_d[D_W-1] ? D_W'(255) : D_W'(0));
    adj_i = prod_i + (prod_i[I_W-1] ? I_W'(255) : I_W'(0));
    p_q   = adj_p[P_W-1:F];
    d_q   = adj_d[D_W-1:F];
    i_q   = adj_i[I_W-1:F];

    total = TOT_W'(p_q) + TOT_W'(d_q) + TOT_W'(i_q);

    max_x = $signed({{(TOT_W-pidz_pkg::LIM_W){1'b0}}, cfg.max_drive});
    min_x = $signed({{(TOT_W-pidz_pkg::LIM_W){1'b0}}, cfg.min_drive});
    if (p_q > 0) begin
      lim_max = max_x;
      lim_min = min_x;
    end else if (p_q < 0) begin
      lim_max = -max_x;
      lim_min = -min_x;
    end else begin
      lim_max = '0;
      lim_min = '0;
    end

    mag0 = total[TOT_W-1] ? $unsigned(-total) : $unsigned(total);
    t1   = (mag0 > $unsigned(max_x)) ? lim_max : total;
    mag1 = t1[TOT_W-1] ? $unsigned(-t1) : $unsigned(t1);
    t2   = (mag1 < $unsigned(min_x)) ? lim_min : t1;

    st_next = st;
    unique case (pidz_pkg::op_t'(op))
      pidz_pkg::OP_SAMPLE: begin
        st_next.last_err     = err;
        st_next.prev_err     = err;
        st_next.first_sample = 1'b0;
        st_next.integ_acc    = acc_new;
        st_next.last_drive   = t2[pidz_pkg::DRV_W-1:0];
        if (st.first_sample) begin
          st_next.elapsed = '0;
        end
      end
      pidz_pkg::OP_TICK: begin
        if (!st.first_sample && st.elapsed != '1) begin
          st_next.elapsed = st.elapsed + 1'b1;
        end
      end
      pidz_pkg::OP_RESTART: begin
        st_next.prev_err     = '0;
        st_next.first_sample = 1'b1;
      end
      default: begin
      end
    endcase

    abs_last = st_next.last_err[pidz_pkg::ERR_W-1]
               ? $unsigned(-{st_next.last_err[pidz_pkg::ERR_W-1], st_next.last_err})
               : $unsigned({1'b0, st_next.last_err});
    fin_next = (abs_last < {1'b0, cfg.exit_threshold})
               || (st_next.elapsed > cfg.timeout_ticks);
  end

endmodule

@@ rtl/pid_with_integral_zone_and_exit.sv @@
// PID controller with integral zone, drive clamps and an exit test. Each input beat
// (error sample, millisecond tick or restart) yields one result beat carrying the latest
// drive and the finished flag. A beat is captured in an input register and its result lands,
// after one pass through the three gain multipliers, the sum and the clamps, in the output
// register unless the output stalls, so one beat can be taken every cycle while it is free.
// Gains and limits must be written on the cfg port while the block is idle; nothing enforces it.
module pid_with_integral_zone_and_exit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic signed [pidz_pkg::ERR_W-1:0]  error_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pidz_pkg::DRV_W-1:0]  drive,
  output logic                               finished,
  input  logic                               cfg_we,
  input  logic [pidz_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pidz_pkg::CFG_W-1:0]         cfg_data
);

  pidz_pkg::cfg_t                       cfg;
  pidz_pkg::state_t                     st;
  pidz_pkg::state_t                     st_next;
  logic                                 fin_next;
  logic                                 s1_valid;
  logic [1:0]                           s1_op;
  logic signed [pidz_pkg::ERR_W-1:0]    s1_err;
  logic                                 advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= '0;
      cfg.integral_zone  <= '0;
      cfg.exit_threshold <= '0;
      cfg.min_drive      <= '0;
      cfg.max_drive      <= '1;
      cfg.timeout_ticks  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidz_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[pidz_pkg::GAIN_W-1:0];
        pidz_pkg::REG_INTEGRAL_ZONE:  cfg.integral_zone  <= cfg_data[15:0];
        pidz_pkg::REG_EXIT_THRESHOLD: cfg.exit_threshold <= cfg_data[15:0];
        pidz_pkg::REG_MIN_DRIVE:      cfg.min_drive      <= cfg_data[pidz_pkg::LIM_W-1:0];
        pidz_pkg::REG_MAX_DRIVE:      cfg.max_drive      <= cfg_data[pidz_pkg::LIM_W-1:0];
        pidz_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= cfg_data[pidz_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op  <= op;
      s1_err <= error_in;
    end
  end

  pidz_calc u_calc (
    .cfg      (cfg),
    .st       (st),
    .op       (s1_op),
    .err      (s1_err),
    .st_next  (st_next),
    .fin_next (fin_next)
  );

  // controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_err     <= '0;
      st.last_err     <= '0;
      st.integ_acc    <= '0;
      st.first_sample <= 1'b1;
      st.elapsed      <= '0;
      st.last_drive   <= '0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      drive    <= st_next.last_drive;
      finished <= fin_next;
    end
  end

endmodule

@@ rtl/pidz_checker.sv @@
module pidz_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [pidz_pkg::DRV_W-1:0]  drive,
  input logic                               finished
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive) && $stable(finished))
    else $error("result beat changed while stalled");

  // input side only waits on a stalled output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // accepted beat passes from the input register to the output when the output is free
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result beat missing");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive != {1'b1, {(pidz_pkg::DRV_W-1){1'b0}}})
    else $error("drive outside range");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind pid_with_integral_zone_and_exit pidz_checker u_pidz_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .finished  (finished)
);

@@ dv/tb_pid_with_integral_zone_and_exit.sv @@
module tb_pid_with_integral_zone_and_exit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [pidz_pkg::DRV_W-1:0] drive;
    logic                              finished;
  } drive_beat_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         op = 2'd0;
  logic signed [pidz_pkg::ERR_W-1:0]  error_in = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [pidz_pkg::DRV_W-1:0]  drive;
  logic                               finished;
  logic                               cfg_we = 1'b0;
  logic [pidz_pkg::IDX_W-1:0]         cfg_index = '0;
  logic [pidz_pkg::CFG_W-1:0]         cfg_data = '0;

  pid_with_integral_zone_and_exit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .error_in  (error_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .finished  (finished),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // controller state as the block should hold it
  pidz_pkg::cfg_t live_cfg;
  int             prev_e;
  int             last_e;
  int             integ_sum;
  int             held_drive;
  bit             fresh_run;
  logic [31:0]    ticks_seen;

  drive_beat_t results_due[$];
  int          mismatches = 0;

  function automatic longint q88(input logic [15:0] gain, input longint v);
    longint g;
    g = gain;
    return (g * v) / 256;
  endfunction

  function automatic longint toward_p(input longint lim, input longint p);
    if (p > 0) return lim;
    if (p < 0) return -lim;
    return 0;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic advance_controller(input logic [1:0] op_v, input logic signed [15:0] e);
    longint ev, p, i, d, total, acc, zone, ceil_l, floor_l, exit_l;
    drive_beat_t want;
    ev = e;
    zone = live_cfg.integral_zone;
    ceil_l = live_cfg.max_drive;
    floor_l = live_cfg.min_drive;
    exit_l = live_cfg.exit_threshold;
    case (op_v)
      pidz_pkg::OP_SAMPLE: begin
        last_e = int'(ev);
        p = q88(live_cfg.prop_gain, ev);
        if (fresh_run) begin
          ticks_seen = '0;
          prev_e = int'(ev);
          fresh_run = 1'b0;
        end
        if (magnitude(ev) < zone) begin
          acc = longint'(integ_sum) + ev;
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          integ_sum = int'(acc);
        end else begin
          integ_sum = 0;
        end
        i = q88(live_cfg.integ_gain, longint'(integ_sum));
        d = q88(live_cfg.deriv_gain, ev - longint'(prev_e));
        total = p + i + d;
        if (magnitude(total) > ceil_l) total = toward_p(ceil_l, p);
        if (magnitude(total) < floor_l) total = toward_p(floor_l, p);
        held_drive = int'(total);
        prev_e = int'(ev);
      end
      pidz_pkg::OP_TICK: begin
        if (!fresh_run && ticks_seen != 32'hFFFF_FFFF) ticks_seen = ticks_seen + 1;
      end
      pidz_pkg::OP_RESTART: begin
        prev_e = 0;
        fresh_run = 1'b1;
      end
      default: begin
      end
    endcase
    want.drive = held_drive[pidz_pkg::DRV_W-1:0];
    want.finished = (magnitude(longint'(last_e)) < exit_l) ||
                    (ticks_seen > live_cfg.timeout_ticks);
    results_due.push_back(want);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, drive %0d", drive));
      end else begin
        want = results_due.pop_front();
        if (drive !== want.drive)
          report_mismatch($sformatf("drive %0d, want %0d", drive, want.drive));
        if (finished !== want.finished)
          report_mismatch($sformatf("finished %0b, want %0b", finished, want.finished));
      end
    end
  end

  // receiver stall pattern, with an occasional long hold
  bit hold_ask = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog on handshake progress
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_beat(input logic [1:0] op_v, input logic signed [15:0] e);
    in_valid <= 1'b1;
    op <= op_v;
    error_in <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_controller(op_v, e);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    op <= 2'($urandom());
    error_in <= 16'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_controller(input pidz_pkg::cfg_t c);
    logic [31:0] val;
    for (int r = 0; r < 8; r++) begin
      case (3'(r))
        pidz_pkg::REG_PROP_GAIN:      val = 32'(c.prop_gain);
        pidz_pkg::REG_INTEG_GAIN:     val = 32'(c.integ_gain);
        pidz_pkg::REG_DERIV_GAIN:     val = 32'(c.deriv_gain);
        pidz_pkg::REG_INTEGRAL_ZONE:  val = 32'(c.integral_zone);
        pidz_pkg::REG_EXIT_THRESHOLD: val = 32'(c.exit_threshold);
        pidz_pkg::REG_MIN_DRIVE:      val = 32'(c.min_drive);
        pidz_pkg::REG_MAX_DRIVE:      val = 32'(c.max_drive);
        default:                      val = c.timeout_ticks;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    live_cfg = c;
  endtask

  function automatic pidz_pkg::cfg_t make_cfg(input logic [15:0] pg, input logic [15:0] ig,
                                              input logic [15:0] dg, input logic [15:0] zone,
                                              input logic [15:0] exit_l,
                                              input logic [22:0] lo,
                                              input logic [22:0] hi, input logic [31:0] tmo);
    pidz_pkg::cfg_t c;
    c.prop_gain = pg;
    c.integ_gain = ig;
    c.deriv_gain = dg;
    c.integral_zone = zone;
    c.exit_threshold = exit_l;
    c.min_drive = lo;
    c.max_drive = hi;
    c.timeout_ticks = tmo;
    return c;
  endfunction

  function automatic pidz_pkg::cfg_t random_cfg();
    pidz_pkg::cfg_t c;
    c.prop_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
    c.integ_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 128));
    c.deriv_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
    c.integral_zone = 16'($urandom_range(0, 32768));
    c.exit_threshold = ($urandom_range(0, 5) == 0) ? 16'd32768 : 16'($urandom_range(0, 400));
    c.min_drive = ($urandom_range(0, 2) == 0) ? 23'd0 : 23'($urandom_range(0, 500));
    c.max_drive = ($urandom_range(0, 2) == 0) ? 23'h7FFFFF : 23'($urandom_range(0, 100000));
    case ($urandom_range(0, 5))
      0: c.timeout_ticks = 32'hFFFF_FFFF;
      1: c.timeout_ticks = $urandom();
      default: c.timeout_ticks = $urandom_range(0, 50);
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_error(input int span);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    if (k < 4) return 16'($urandom());
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // mostly samples and ticks, with restarts and the unused op mixed in
  task automatic run_control_loop(input int items, input int span);
    int left, burst, k;
    logic [1:0] o;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        k = $urandom_range(0, 99);
        if (k < 55) o = pidz_pkg::OP_SAMPLE;
        else if (k < 88) o = pidz_pkg::OP_TICK;
        else if (k < 97) o = pidz_pkg::OP_RESTART;
        else o = OP_UNUSED;
        push_beat(o, pick_error(span));
        burst--;
        left--;
      end
      k = $urandom_range(0, 9);
      if (k >= 3) pause_sender((k == 9) ? $urandom_range(10, 40) : $urandom_range(1, 6));
    end
  endtask

  task automatic test_after_reset();
    push_beat(pidz_pkg::OP_TICK, 16'sd0);
    push_beat(OP_UNUSED, 16'sd5);
    push_beat(pidz_pkg::OP_RESTART, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh7FFF);
    push_beat(pidz_pkg::OP_TICK, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh8000);
    settle();
  endtask

  task automatic test_directed_cases();
    program_controller(make_cfg(16'h0180, 16'h0040, 16'h0200, 16'd2000, 16'd40,
                                23'd60, 23'd30000, 32'd3));
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd100);
    repeat (4) push_beat(pidz_pkg::OP_TICK, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh8000);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh7FFF);
    push_beat(pidz_pkg::OP_SAMPLE, -16'sd20);
    push_beat(pidz_pkg::OP_RESTART, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd5);
    push_beat(OP_UNUSED, -16'sd1);
    push_beat(pidz_pkg::OP_TICK, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, -16'sd1);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd1);
    settle();
    program_controller(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000,
                                23'd0, 23'h7FFFFF, 32'hFFFF_FFFF));
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh7FFF);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh8000);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd0);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh7FFF);
    settle();
  endtask

  // long integral runs in both directions inside a wide zone
  task automatic test_integral_windup();
    program_controller(make_cfg(16'h0001, 16'h0001, 16'h0000, 16'h8000, 16'd0,
                                23'd0, 23'h7FFFFF, 32'hFFFF_FFFF));
    push_beat(pidz_pkg::OP_RESTART, 16'sd0);
    repeat (40) push_beat(pidz_pkg::OP_SAMPLE, 16'sh7FFF);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sh8000);
    repeat (40) push_beat(pidz_pkg::OP_SAMPLE, -16'sd32767);
    push_beat(pidz_pkg::OP_SAMPLE, 16'sd3);
    settle();
  endtask

  task automatic test_config_extremes();
    program_controller(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000,
                                23'd0, 23'h7FFFFF, 32'hFFFF_FFFF));
    run_control_loop(60, 32767);
    settle();
    program_controller(make_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                23'h7FFFFF, 23'd0, 32'd0));
    run_control_loop(60, 32767);
    settle();
    program_controller(make_cfg(16'h0100, 16'h0010, 16'h0100, 16'd500, 16'd20,
                                23'h7FFFFF, 23'h7FFFFF, 32'd0));
    run_control_loop(60, 600);
    settle();
  endtask

  task automatic test_backpressure();
    program_controller(random_cfg());
    hold_ask = 1'b1;
    run_control_loop(150, 2000);
    settle();
    run_control_loop(40, 2000);
    settle();
  endtask

  task automatic test_random_control();
    for (int s = 0; s < 6; s++) begin
      program_controller(random_cfg());
      run_control_loop(120, $urandom_range(50, 32767));
      settle();
    end
  endtask

  initial begin
    live_cfg = make_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 23'd0, 23'h7FFFFF,
                        32'hFFFF_FFFF);
    prev_e = 0;
    last_e = 0;
    integ_sum = 0;
    held_drive = 0;
    fresh_run = 1'b1;
    ticks_seen = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_directed_cases();
    test_integral_windup();
    test_config_extremes();
    test_backpressure();
    test_random_control();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pidz_pkg.sv
rtl/pidz_calc.sv
rtl/pid_with_integral_zone_and_exit.sv
rtl/pidz_checker.sv
dv/tb_pid_with_integral_zone_and_exit.sv
